/* hdl/int_to_radix_ascii_padded_top_assert.svh */
// Assertion macros shared by the converter modules
`ifndef INT_TO_RADIX_ASCII_PADDED_TOP_ASSERT_SVH
`define INT_TO_RADIX_ASCII_PADDED_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define ITRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ITRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/itra_pkg.sv */
// Constants, types and helper functions for the radix text converter
package itra_pkg;

  localparam int WORD_BITS     = 32;
  localparam int MAX_CHARS     = 64;
  localparam int RADIX_W       = 6;
  localparam int WIDTH_W       = 7;
  localparam int CHAR_W        = 7;
  localparam int MAX_DIGITS    = WORD_BITS;
  localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W        = $clog2(MAX_DIGITS);
  localparam int BITS_PER_STEP = 4;
  localparam int DIV_STEPS     = WORD_BITS / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_CHARS);

  // register indexes
  localparam logic REG_RADIX = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [RADIX_W-1:0] DEC_LAST  = RADIX_W'(9);
  localparam logic [CHAR_W-1:0] DEC_BASE   = CHAR_W'(10);

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [WIDTH_W-1:0] width;
  } cfg_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d > DEC_LAST) begin
      return dw + CHAR_A - DEC_BASE;
    end
    return dw + CHAR_ZERO;
  endfunction

endpackage

/* hdl/itra_chan_if.sv */
// Valid/ready channel interfaces for input words and output characters
interface itra_in_if import itra_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface itra_out_if import itra_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

/* hdl/int_to_radix_ascii_padded_top.sv */
// Top level: sequencer, digit store and output register of the radix converter
// Sequence: the shared divider yields one digit per division into the store, then pad spaces,
//   the sign and the stored digits are emitted in that order, each digit read from the store
//   in S_RD before S_DIG loads it; output stalls hold each step. A new value is accepted only
//   once the last digit is out, in S_IDLE; the divider takes four quotient bits a cycle.
//   Reset: radix 10, width 0, digit count and handshakes cleared; store undefined.
module int_to_radix_ascii_padded_top import itra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  itra_in_if.sink               in_ch,
  itra_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_DIG  = 3'd5;

  cfg_t cfg;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WIDTH_W-1:0]   pad_r, pad_nxt;
  logic                 neg_r, neg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [RADIX_W-1:0]   mem [MAX_DIGITS];
  logic [RADIX_W-1:0]   rd_data_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;

  logic                 accept;
  logic                 slot_free;
  logic                 load;
  logic                 div_start;
  logic [WORD_BITS-1:0] div_dividend;
  logic                 div_done;
  logic [WORD_BITS-1:0] div_quo;
  logic [RADIX_W-1:0]   div_rem;
  logic [WORD_BITS-1:0] mag;
  logic [WIDTH_W-1:0]   total;

  itra_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  itra_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .base      (cfg.radix),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign accept           = in_ch.valid && in_ch.ready;
  assign mag              = in_ch.value[WORD_BITS-1] ? (WORD_BITS'(0) - WORD_BITS'(in_ch.value))
                                                     : WORD_BITS'(in_ch.value);
  assign slot_free        = !out_valid_r || out_ch.ready;
  assign wr_en            = (state_r == S_DIV) && div_done;
  assign div_start        = accept || (wr_en && (div_quo != '0));
  assign div_dividend     = accept ? mag : div_quo;
  assign rd_addr          = ADDR_W'(cnt_r - CNT_W'(1));
  assign total            = WIDTH_W'(cnt_r) + WIDTH_W'(1) + WIDTH_W'(neg_r);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pad_nxt      = pad_r;
    neg_nxt      = neg_r;
    load         = 1'b0;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt   = in_ch.value[WORD_BITS-1];
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (div_quo == '0) begin
            pad_nxt = (cfg.width > total) ? (cfg.width - total) : '0;
            if (cfg.width > total) begin
              state_nxt = S_PAD;
            end else if (neg_r) begin
              state_nxt = S_SIGN;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_PAD: begin
        if (slot_free) begin
          load         = 1'b1;
          out_char_nxt = CHAR_SPACE;
          out_last_nxt = 1'b0;
          pad_nxt      = pad_r - WIDTH_W'(1);
          if (pad_r == WIDTH_W'(1)) begin
            state_nxt = neg_r ? S_SIGN : S_RD;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          load         = 1'b1;
          out_char_nxt = CHAR_MINUS;
          out_last_nxt = 1'b0;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_DIG;
      end
      S_DIG: begin
        if (slot_free) begin
          load         = 1'b1;
          out_char_nxt = digit_char(rd_data_r);
          out_last_nxt = (cnt_r == CNT_W'(1));
          cnt_nxt      = cnt_r - CNT_W'(1);
          state_nxt    = (cnt_r == CNT_W'(1)) ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pad_r      <= pad_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[ADDR_W-1:0]] <= div_rem;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  `include "int_to_radix_ascii_padded_top_assert.svh"

  `ITRA_ASSERT_NOW(a_store_room, wr_en, cnt_r < CNT_W'(MAX_DIGITS), "digit store overrun")
  `ITRA_ASSERT_NOW(a_dig_nonempty, state_r == S_DIG, cnt_r != '0, "emit with no digits held")
  `ITRA_ASSERT_NEXT(a_last_idle, load && out_last_nxt, state_r == S_IDLE,
                    "last character not followed by idle")

endmodule

/* hdl/itra_cfg.sv */
// APB register block holding radix and minimum width
module itra_cfg import itra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg_o
);

  logic [RADIX_W-1:0] radix_r;
  logic [WIDTH_W-1:0] width_r;
  logic               reg_idx;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      width_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RADIX: radix_r <= cfg_pwdata[RADIX_W-1:0];
        REG_WIDTH: width_r <= cfg_pwdata[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RADIX: cfg_prdata = CFG_DATA_W'(radix_r);
      REG_WIDTH: cfg_prdata = CFG_DATA_W'(width_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // saturate to the usable range
  always_comb begin
    cfg_o.radix = radix_r;
    if (radix_r < RADIX_MIN) begin
      cfg_o.radix = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      cfg_o.radix = RADIX_MAX;
    end
    cfg_o.width = (width_r > WIDTH_MAX) ? WIDTH_MAX : width_r;
  end

endmodule

/* hdl/itra_div.sv */
// Shared divider, four quotient bits per cycle by restoring subtraction
module itra_div import itra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]   base,
  output logic                 done,
  output logic [WORD_BITS-1:0] quotient,
  output logic [RADIX_W-1:0]   remainder
);

  logic [WORD_BITS-1:0] num_r, num_nxt;
  logic [RADIX_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]    step_r;
  logic                 busy_r;
  logic                 done_r;
  logic [RADIX_W:0]     trial;

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial   = {rem_nxt, num_nxt[WORD_BITS-1]};
      num_nxt = {num_nxt[WORD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, base}) begin
        trial      = trial - {1'b0, base};
        num_nxt[0] = 1'b1;
      end
      rem_nxt = trial[RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = num_r;
  assign remainder = rem_r;

  `include "int_to_radix_ascii_padded_top_assert.svh"

  `ITRA_ASSERT_NOW(a_done_idle, done_r, !busy_r, "divider done while still busy")
  `ITRA_ASSERT_NOW(a_rem_below_base, done_r, rem_r < base, "remainder not below base")
  `ITRA_ASSERT_NEXT(a_start_busy, start, busy_r, "divider idle after start")

endmodule
